[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/lcasr_pkg.sv]
package lcasr_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int SAMPLE_W        = 24;
   localparam int HOLD_W          = 16;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd65;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_READ = 2'd1,
      MODE_PDOWN = 2'd2,
      MODE_PUP = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NOT_READY = 3'd1,
      ST_POWER = 3'd2,
      ST_PARAM = 3'd3,
      ST_BUSY = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BIT_HIGH = 3'd1,
      PH_BIT_LOW = 3'd2,
      PH_EXTRA_HIGH = 3'd3,
      PH_EXTRA_LOW = 3'd4,
      PH_PD_HOLD = 3'd5
   } phase_type;

   // Request beat, lowest field in the lowest bits.
   typedef struct packed {
      logic [1:0] gain_pulses;
      logic       data_pin;
      mode_type   mode;
   } req_type;

   // Result beat, lowest field in the lowest bits.
   typedef struct packed {
      logic                       status_valid;
      status_type                 status;
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clock_pin;
   } rsp_type;

endpackage

[rtl/load_cell_adc_serial_reader.sv]
// Two-wire load-cell converter master, one pin-timing tick per request beat.
// req channel: one beat per tick carrying mode, sampled data pin level and
//   the extra gain pulse count. Every request beat gives exactly one rsp beat.
// rsp channel: clock pin level for the tick, sign-extended sample with its
//   valid flag, and the status answer with its valid flag.
// csr channel: write of the power-down hold length in ticks; write it only
//   while no sequence is running and no beat is in flight.
// Path: a request beat goes through the input register, then the result
//   register, with the tick logic between them.
// Throughput: one beat per cycle while rsp_tready stays high; the limit is
//   the single tick update of the sequencer state between the two registers.
// A read takes 2*SAMPLE_BITS + 2*gain_pulses + 1 ticks from request to sample.
// Reset: sequencer idle, clock low, powered up, hold length 65, both stages
//   empty.
// Stall: when rsp_tready is low the result register holds its beat, the input
//   register takes one more beat, and req_tready then drops until the result
//   is taken.
module load_cell_adc_serial_reader #(
   parameter int SAMPLE_BITS = lcasr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] mode, [2] data_pin, [4:3] gain_pulses, [7:5] zero
   input  logic [7:0]                   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] clock_pin, [24:1] sample, [25] sample_valid, [28:26] status,
   // [29] status_valid, [31:30] zero
   output logic [31:0]                  rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lcasr_pkg::HOLD_W-1:0] csr_data
);
   import lcasr_pkg::*;

   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

   logic              in_vld_ff, in_vld_in;
   req_type           in_req_ff;
   logic              out_vld_ff, out_vld_in;
   rsp_type           out_rsp_ff;
   rsp_type           step_rsp;
   logic              advance;
   logic [HOLD_W-1:0] hold_ticks;

   // Move the input beat on when the result register is free or draining
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff <= req_type'(req_tdata[REQ_W-1:0]);
      end
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   lcasr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .hold_ticks (hold_ticks)
   );

   lcasr_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .req        (in_req_ff),
      .hold_ticks (hold_ticks),
      .rsp        (step_rsp)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(32 - RSP_W)'(0), out_rsp_ff};

endmodule

[rtl/lcasr_csr.sv]
module lcasr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lcasr_pkg::HOLD_W-1:0] csr_data,
   output logic [lcasr_pkg::HOLD_W-1:0] hold_ticks
);
   import lcasr_pkg::*;

   logic [HOLD_W-1:0] hold_ticks_ff;
   logic [HOLD_W-1:0] hold_ticks_in;

   // Take every write beat at once
   assign csr_ready = 1'b1;

   always_comb begin
      hold_ticks_in = hold_ticks_ff;
      if (csr_valid) begin
         hold_ticks_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_RESET;
      end else begin
         hold_ticks_ff <= hold_ticks_in;
      end
   end

   assign hold_ticks = hold_ticks_ff;

endmodule

[rtl/lcasr_core.sv]
module lcasr_core #(
   parameter int SAMPLE_BITS = lcasr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  lcasr_pkg::req_type           req,
   input  logic [lcasr_pkg::HOLD_W-1:0] hold_ticks,
   output lcasr_pkg::rsp_type           rsp
);
   import lcasr_pkg::*;

   localparam int CNT_W = $clog2(SAMPLE_BITS);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SAMPLE_BITS - 1);

   phase_type              phase_ff, phase_in;
   logic                   clock_ff, clock_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [1:0]             pulses_ff, pulses_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic                   pdown_ff, pdown_in;
   logic [HOLD_W-1:0]      hold_start;
   logic [1:0]             pulses_dec;
   logic [HOLD_W-1:0]      hold_dec;

   assign hold_start = (hold_ticks == '0) ? '0 : hold_ticks - HOLD_W'(1);
   assign pulses_dec = pulses_ff - 2'd1;
   assign hold_dec   = hold_ff - HOLD_W'(1);

   // Next state and result for the tick at the input stage
   always_comb begin
      phase_in   = phase_ff;
      clock_in   = clock_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      pulses_in  = pulses_ff;
      hold_in    = hold_ff;
      pdown_in   = pdown_ff;
      rsp        = '0;

      if (phase_ff == PH_IDLE) begin
         case (req.mode)
            MODE_READ: begin
               rsp.status_valid = 1'b1;
               if (req.gain_pulses == 2'd0) begin
                  rsp.status = ST_PARAM;
               end else if (pdown_ff) begin
                  rsp.status = ST_POWER;
               end else if (req.data_pin) begin
                  rsp.status = ST_NOT_READY;
               end else begin
                  rsp.status = ST_OK;
                  clock_in   = 1'b0;
                  bit_cnt_in = '0;
                  shift_in   = '0;
                  pulses_in  = req.gain_pulses;
                  phase_in   = PH_BIT_HIGH;
               end
            end
            MODE_PDOWN: begin
               rsp.status_valid = 1'b1;
               if (pdown_ff) begin
                  rsp.status = ST_POWER;
               end else begin
                  rsp.status = ST_OK;
                  clock_in   = 1'b1;
                  hold_in    = hold_start;
                  if (hold_start == '0) begin
                     pdown_in = 1'b1;
                  end else begin
                     phase_in = PH_PD_HOLD;
                  end
               end
            end
            MODE_PUP: begin
               rsp.status_valid = 1'b1;
               if (!pdown_ff) begin
                  rsp.status = ST_POWER;
               end else begin
                  rsp.status = ST_OK;
                  clock_in   = 1'b0;
                  pdown_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else begin
         // Refuse requests while a sequence runs
         if (req.mode != MODE_IDLE) begin
            rsp.status_valid = 1'b1;
            rsp.status       = ST_BUSY;
         end
         case (phase_ff)
            PH_BIT_HIGH: begin
               clock_in = 1'b1;
               shift_in = {shift_ff[SAMPLE_BITS-2:0], req.data_pin};
               phase_in = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               clock_in = 1'b0;
               if (bit_cnt_ff == LAST_BIT) begin
                  bit_cnt_in = '0;
                  phase_in   = PH_EXTRA_HIGH;
               end else begin
                  bit_cnt_in = bit_cnt_ff + CNT_W'(1);
                  phase_in   = PH_BIT_HIGH;
               end
            end
            PH_EXTRA_HIGH: begin
               clock_in = 1'b1;
               phase_in = PH_EXTRA_LOW;
            end
            PH_EXTRA_LOW: begin
               clock_in  = 1'b0;
               pulses_in = pulses_dec;
               if (pulses_dec == 2'd0) begin
                  rsp.sample       = SAMPLE_W'($signed(shift_ff));
                  rsp.sample_valid = 1'b1;
                  phase_in         = PH_IDLE;
               end else begin
                  phase_in = PH_EXTRA_HIGH;
               end
            end
            PH_PD_HOLD: begin
               clock_in = 1'b1;
               hold_in  = hold_dec;
               if (hold_dec == '0) begin
                  pdown_in = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      rsp.clock_pin = clock_in;
   end

   // Advance state only when the tick moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         clock_ff   <= 1'b0;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         pulses_ff  <= '0;
         hold_ff    <= '0;
         pdown_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         clock_ff   <= clock_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         pulses_ff  <= pulses_in;
         hold_ff    <= hold_in;
         pdown_ff   <= pdown_in;
      end
   end

endmodule

[rtl/lcasr_checker.sv]
`include "assert_macros.svh"

module lcasr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Hold a stalled result beat
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Give a sample only on a low clock tick
   `ASSERT_IMPLIES(a_sample_low, clock, reset, rsp_tvalid && rsp_tdata[25], !rsp_tdata[0])

   // Keep the sample zero without its valid flag
   `ASSERT_IMPLIES(a_sample_zero, clock, reset, rsp_tvalid && !rsp_tdata[25], rsp_tdata[24:1] == 24'd0)

   // Keep status zero without its valid flag, and within the defined codes
   `ASSERT_IMPLIES(a_status_zero, clock, reset, rsp_tvalid && !rsp_tdata[29], rsp_tdata[28:26] == 3'd0)
   `ASSERT_IMPLIES(a_status_code, clock, reset, rsp_tvalid && rsp_tdata[28], rsp_tdata[27:26] == 2'd0)

endmodule

bind load_cell_adc_serial_reader lcasr_checker u_lcasr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import lcasr_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int TAIL_CYCLES  = 8;

   // Tracks the pin sequencer tick by tick and holds the result beats still owed.
   class reader_scoreboard;
      phase_type           ph;
      logic                clk_lvl;
      logic [4:0]          bit_cnt;
      logic [SAMPLE_W-1:0] shift_reg;
      logic [1:0]          pulses_left;
      logic [HOLD_W-1:0]   hold_left;
      logic                pwr_down;
      logic [HOLD_W-1:0]   hold_cfg;
      rsp_type             owed_beats[$];
      int                  errors;

      function new();
         ph          = PH_IDLE;
         clk_lvl     = 1'b0;
         bit_cnt     = '0;
         shift_reg   = '0;
         pulses_left = '0;
         hold_left   = '0;
         pwr_down    = 1'b0;
         hold_cfg    = HOLD_RESET;
         errors      = 0;
      endfunction

      // Advance one tick and queue the beat it must produce.
      function void note_tick(req_type r);
         rsp_type e;
         e = '0;
         if (ph == PH_IDLE) begin
            if (r.mode == MODE_READ) begin
               e.status_valid = 1'b1;
               if (r.gain_pulses == 2'd0) begin
                  e.status = ST_PARAM;
               end else if (pwr_down) begin
                  e.status = ST_POWER;
               end else if (r.data_pin) begin
                  e.status = ST_NOT_READY;
               end else begin
                  clk_lvl     = 1'b0;
                  bit_cnt     = '0;
                  shift_reg   = '0;
                  pulses_left = r.gain_pulses;
                  ph          = PH_BIT_HIGH;
               end
            end else if (r.mode == MODE_PDOWN) begin
               e.status_valid = 1'b1;
               if (pwr_down) begin
                  e.status = ST_POWER;
               end else begin
                  // zero hold length behaves as one tick
                  clk_lvl   = 1'b1;
                  hold_left = (hold_cfg == '0) ? '0 : hold_cfg - 1'b1;
                  if (hold_left == '0) pwr_down = 1'b1;
                  else ph = PH_PD_HOLD;
               end
            end else if (r.mode == MODE_PUP) begin
               e.status_valid = 1'b1;
               if (!pwr_down) begin
                  e.status = ST_POWER;
               end else begin
                  clk_lvl  = 1'b0;
                  pwr_down = 1'b0;
               end
            end
         end else begin
            // any request mid-sequence is refused, the sequence goes on
            if (r.mode != MODE_IDLE) begin
               e.status_valid = 1'b1;
               e.status       = ST_BUSY;
            end
            case (ph)
               PH_BIT_HIGH: begin
                  clk_lvl   = 1'b1;
                  shift_reg = {shift_reg[SAMPLE_W-2:0], r.data_pin};
                  ph        = PH_BIT_LOW;
               end
               PH_BIT_LOW: begin
                  clk_lvl = 1'b0;
                  if (bit_cnt == 5'(SAMPLE_W - 1)) begin
                     bit_cnt = '0;
                     ph      = PH_EXTRA_HIGH;
                  end else begin
                     bit_cnt = bit_cnt + 1'b1;
                     ph      = PH_BIT_HIGH;
                  end
               end
               PH_EXTRA_HIGH: begin
                  clk_lvl = 1'b1;
                  ph      = PH_EXTRA_LOW;
               end
               PH_EXTRA_LOW: begin
                  clk_lvl     = 1'b0;
                  pulses_left = pulses_left - 1'b1;
                  if (pulses_left == 2'd0) begin
                     e.sample       = shift_reg;
                     e.sample_valid = 1'b1;
                     ph             = PH_IDLE;
                  end else begin
                     ph = PH_EXTRA_HIGH;
                  end
               end
               PH_PD_HOLD: begin
                  clk_lvl   = 1'b1;
                  hold_left = hold_left - 1'b1;
                  if (hold_left == '0) begin
                     pwr_down = 1'b1;
                     ph       = PH_IDLE;
                  end
               end
               default: ph = PH_IDLE;
            endcase
         end
         e.clock_pin = clk_lvl;
         owed_beats.push_back(e);
      endfunction

      function void report(string field, int want, int got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      endfunction

      // Compare a result beat with the oldest owed beat.
      function void check_beat(logic [31:0] beat);
         rsp_type want;
         rsp_type got;
         if (owed_beats.size() == 0) begin
            $display("%0t: result beat %h with none expected", $time, beat);
            errors++;
            return;
         end
         want = owed_beats.pop_front();
         got  = rsp_type'(beat[29:0]);
         if (got.clock_pin != want.clock_pin)
            report("clock_pin", want.clock_pin, got.clock_pin);
         if (got.sample != want.sample)
            report("sample", want.sample, got.sample);
         if (got.sample_valid != want.sample_valid)
            report("sample_valid", want.sample_valid, got.sample_valid);
         if (got.status != want.status)
            report("status", want.status, got.status);
         if (got.status_valid != want.status_valid)
            report("status_valid", want.status_valid, got.status_valid);
         if (beat[31:30] != 2'b00)
            report("padding", 0, beat[31:30]);
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [HOLD_W-1:0] csr_data   = '0;

   reader_scoreboard sb;
   bit               steady      = 1'b0;
   int               ticks_sent  = 0;
   int               cycles      = 0;
   int               stall_left  = 0;
   int               free_left   = 0;
   int               burst_left  = 0;

   load_cell_adc_serial_reader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Bound the run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb failed");
         $finish;
      end
   end

   // Idle stretch length: mostly short, now and then long.
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
      return $urandom_range(1, 3);
   endfunction

   // Check result beats and stall the result side at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
      if (steady || free_left > 0) begin
         if (free_left > 0) free_left--;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         case ($urandom_range(0, 199)) inside
            [0:1]:  free_left = $urandom_range(100, 400);
            [2:40]: stall_left = idle_len();
            default: ;
         endcase
      end
   end

   function automatic req_type make_req(mode_type m, logic d, logic [1:0] g);
      req_type r;
      r.mode        = m;
      r.data_pin    = d;
      r.gain_pulses = g;
      return r;
   endfunction

   function automatic req_type any_req();
      return make_req(mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      2'($urandom_range(0, 3)));
   endfunction

   // Send one tick beat after an optional gap, then advance the model.
   task automatic send_tick(req_type r);
      int gap;
      gap = 0;
      if (!steady) begin
         if (burst_left > 0) burst_left--;
         else if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(50, 150);
         else if ($urandom_range(0, 99) < 35) gap = idle_len();
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(r);
      ticks_sent++;
   endtask

   // Tick the sequencer until it is idle, feeding the pattern MSB first on the
   // high clock ticks and sprinkling refused requests.
   task automatic run_to_idle(logic [SAMPLE_W-1:0] pattern, int busy_pct);
      req_type r;
      while (sb.ph != PH_IDLE) begin
         r = any_req();
         if ($urandom_range(0, 99) >= busy_pct) r.mode = MODE_IDLE;
         else if (r.mode == MODE_IDLE) r.mode = MODE_READ;
         if (sb.ph == PH_BIT_HIGH) r.data_pin = pattern[SAMPLE_W - 1 - sb.bit_cnt];
         send_tick(r);
      end
   endtask

   // Bring the block to rest and write the hold length.
   task automatic write_hold(logic [HOLD_W-1:0] value);
      run_to_idle(SAMPLE_W'($urandom()), 0);
      req_tvalid <= 1'b0;
      while (sb.owed_beats.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid  <= 1'b1;
      csr_data   <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      sb.hold_cfg  = value;
   endtask

   // Random traffic: mostly clean reads, plus power cycles and raw noise.
   task automatic random_ticks(int budget);
      int start;
      int pick;
      start = ticks_sent;
      while (ticks_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if (sb.pwr_down) send_tick(make_req(MODE_PUP, 1'($urandom), 2'($urandom)));
            send_tick(make_req(MODE_READ, 1'b0, 2'($urandom_range(1, 3))));
            case ($urandom_range(0, 9))
               0:       run_to_idle('1, 6);
               1:       run_to_idle('0, 6);
               default: run_to_idle(SAMPLE_W'($urandom()), 6);
            endcase
         end else if (pick < 62) begin
            send_tick(make_req(MODE_PDOWN, 1'($urandom), 2'($urandom)));
            run_to_idle(SAMPLE_W'($urandom()), 6);
         end else if (pick < 70) begin
            send_tick(make_req(MODE_PUP, 1'($urandom), 2'($urandom)));
         end else begin
            repeat ($urandom_range(1, 4)) send_tick(any_req());
            run_to_idle(SAMPLE_W'($urandom()), 10);
         end
      end
   endtask

   initial begin
      logic [HOLD_W-1:0] hold_plan[6];
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Refused reads, power-up while up, and reads at the sample extremes.
      send_tick(make_req(MODE_IDLE, 1'b1, 2'd3));
      send_tick(make_req(MODE_IDLE, 1'b0, 2'd0));
      send_tick(make_req(MODE_READ, 1'b0, 2'd0));
      send_tick(make_req(MODE_READ, 1'b1, 2'd2));
      send_tick(make_req(MODE_PUP, 1'b0, 2'd1));
      send_tick(make_req(MODE_READ, 1'b0, 2'd1));
      run_to_idle(24'hFFFFFF, 30);
      send_tick(make_req(MODE_READ, 1'b0, 2'd3));
      run_to_idle(24'h7FFFFF, 0);
      send_tick(make_req(MODE_READ, 1'b0, 2'd2));
      run_to_idle(24'h800000, 0);

      // Power down at the reset hold length, then requests while down.
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      run_to_idle('0, 20);
      send_tick(make_req(MODE_PDOWN, 1'b1, 2'd1));
      send_tick(make_req(MODE_READ, 1'b1, 2'd0));
      send_tick(make_req(MODE_READ, 1'b1, 2'd1));
      send_tick(make_req(MODE_READ, 1'b0, 2'd3));
      send_tick(make_req(MODE_PUP, 1'b0, 2'd0));

      // Shortest hold, and a zero hold that behaves as one tick.
      write_hold(16'd1);
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      send_tick(make_req(MODE_PUP, 1'b1, 2'd2));
      write_hold(16'd0);
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      send_tick(make_req(MODE_PUP, 1'b0, 2'd0));
      write_hold(16'd2);
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      send_tick(make_req(MODE_READ, 1'b0, 2'd1));
      send_tick(make_req(MODE_PUP, 1'b0, 2'd0));

      // Long hold, run without idling on either side.
      write_hold(16'd150);
      steady = 1'b1;
      send_tick(make_req(MODE_PDOWN, 1'b0, 2'd0));
      run_to_idle('0, 5);
      send_tick(make_req(MODE_PUP, 1'b0, 2'd0));
      steady = 1'b0;

      hold_plan[0] = 16'd3;
      hold_plan[1] = HOLD_RESET;
      hold_plan[2] = 16'd1;
      hold_plan[3] = 16'($urandom_range(4, 30));
      hold_plan[4] = 16'd0;
      hold_plan[5] = 16'($urandom_range(1, 100));
      foreach (hold_plan[i]) begin
         write_hold(hold_plan[i]);
         random_ticks(120);
      end

      // Drain and finish.
      run_to_idle(SAMPLE_W'($urandom()), 0);
      req_tvalid <= 1'b0;
      while (sb.owed_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/lcasr_pkg.sv
rtl/lcasr_csr.sv
rtl/lcasr_core.sv
rtl/load_cell_adc_serial_reader.sv
rtl/lcasr_checker.sv
tb/tb.sv
